FILE: src/assert_macros.svh
// Assertion macros for the section translator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Implication or plain property, checked on every rising edge out of reset.
`define SRT_ASSERT(lbl, clk, rst_n, prop) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("section translator property violated");
// Condition that must never be seen on a rising edge out of reset.
`define SRT_NEVER(lbl, clk, rst_n, expr) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
	else $error("section translator forbidden condition seen");
`else
`define SRT_ASSERT(lbl, clk, rst_n, prop)
`define SRT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

FILE: src/srt_pkg.sv
// Types and constants of the section translator.
package srt_pkg;

	localparam int unsigned MAX_SECTIONS_DEF = 16;

	localparam int unsigned IDX_W   = 4;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned ADDR_W  = 64;
	localparam int unsigned COUNT_W = 5;

	// entry_index, vaddr, vsize, rawsize, rawptr, rva = 164 bits, padded
	localparam int unsigned S_TDATA_W = 168;
	// section_index, physical_address = 68 bits, padded
	localparam int unsigned M_TDATA_W = 72;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_XLATE = 1'b1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NONE   = 2'd1;
	localparam logic [1:0] ST_BEYOND = 2'd2;

	localparam logic REG_COUNT = 1'b0;
	localparam logic REG_BASE  = 1'b1;

	// One beat moving down the cell chain. For a translate beat that has
	// found its section, vaddr/rawsize/rawptr hold the matched entry.
	typedef struct packed {
		logic              valid;
		logic              cmd;
		logic [IDX_W-1:0]  entry_index;
		logic [WORD_W-1:0] vaddr;
		logic [WORD_W-1:0] vsize;
		logic [WORD_W-1:0] rawsize;
		logic [WORD_W-1:0] rawptr;
		logic [WORD_W-1:0] rva;
		logic              found;
		logic [IDX_W-1:0]  hit_idx;
	} beat_t;

	typedef struct packed {
		logic              valid;
		logic [1:0]        status;
		logic [IDX_W-1:0]  section_index;
		logic [ADDR_W-1:0] phys;
	} result_t;

endpackage

FILE: src/srt_cell.sv
// One table cell: holds one section entry and checks passing translate beats.
module srt_cell #(
	parameter int unsigned CELL_ID = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          advance,
	input  logic [srt_pkg::COUNT_W-1:0]   section_count,
	input  srt_pkg::beat_t                beat_in,
	output srt_pkg::beat_t                beat_out
);
	import srt_pkg::*;

	logic [WORD_W-1:0] vaddr_q;
	logic [WORD_W:0]   end_q;
	logic [WORD_W-1:0] rawsize_q;
	logic [WORD_W-1:0] rawptr_q;

	logic              valid_q;
	beat_t             beat_q;
	beat_t             beat_nxt;
	logic              load_here;
	logic              hit;
	logic [WORD_W-1:0] span;

	assign load_here = beat_in.valid && (beat_in.cmd == CMD_LOAD)
		&& (32'(beat_in.entry_index) == CELL_ID);
	assign span = (beat_in.vsize > beat_in.rawsize) ? beat_in.vsize : beat_in.rawsize;

	assign hit = beat_in.valid && (beat_in.cmd == CMD_XLATE) && !beat_in.found
		&& (CELL_ID < 32'(section_count))
		&& (beat_in.rva >= vaddr_q) && ({1'b0, beat_in.rva} <= end_q);

	always_comb begin
		beat_nxt = beat_in;
		if (hit) begin
			beat_nxt.found   = 1'b1;
			beat_nxt.hit_idx = IDX_W'(CELL_ID);
			beat_nxt.vaddr   = vaddr_q;
			beat_nxt.rawsize = rawsize_q;
			beat_nxt.rawptr  = rawptr_q;
		end
	end

	// Store the entry; the span end is summed one bit wider so it never wraps.
	always_ff @(posedge clk) begin
		if (advance && load_here) begin
			vaddr_q   <= beat_in.vaddr;
			end_q     <= {1'b0, beat_in.vaddr} + {1'b0, span};
			rawsize_q <= beat_in.rawsize;
			rawptr_q  <= beat_in.rawptr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= beat_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			beat_q <= beat_nxt;
		end
	end

	always_comb begin
		beat_out       = beat_q;
		beat_out.valid = valid_q;
	end

endmodule

FILE: src/srt_resolve.sv
// Tail of the chain: offset check, address sum and the output register.
module srt_resolve (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [srt_pkg::ADDR_W-1:0]  buffer_base,
	input  srt_pkg::beat_t              beat_in,
	input  logic                        out_ready,
	output logic                        advance,
	output srt_pkg::result_t            result
);
	import srt_pkg::*;

	logic              valid_s1;
	logic              found_s1;
	logic              beyond_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [WORD_W:0]   sum_s1;
	logic [WORD_W-1:0] offset;

	logic              out_valid_q;
	logic [1:0]        status_q;
	logic [IDX_W-1:0]  idx_q;
	logic [ADDR_W-1:0] phys_q;

	assign advance = !out_valid_q || out_ready;
	assign offset  = beat_in.rva - beat_in.vaddr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			// drop load beats here: they give no result
			valid_s1    <= beat_in.valid && (beat_in.cmd == CMD_XLATE);
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			found_s1  <= beat_in.found;
			beyond_s1 <= offset >= beat_in.rawsize;
			idx_s1    <= beat_in.hit_idx;
			sum_s1    <= {1'b0, beat_in.rawptr} + {1'b0, offset};
			if (!found_s1) begin
				status_q <= ST_NONE;
				idx_q    <= '0;
				phys_q   <= '0;
			end else if (beyond_s1) begin
				status_q <= ST_BEYOND;
				idx_q    <= idx_s1;
				phys_q   <= '0;
			end else begin
				status_q <= ST_OK;
				idx_q    <= idx_s1;
				phys_q   <= buffer_base + ADDR_W'(sum_s1);
			end
		end
	end

	always_comb begin
		result.valid         = out_valid_q;
		result.status        = status_q;
		result.section_index = idx_q;
		result.phys          = phys_q;
	end

endmodule

FILE: src/section_rva_translator.sv
// Section translator top level: beat interfaces, configuration and cell chain.
//
// Use: the slave stream takes one command per beat. tuser = 0 loads a table
// entry (slot, virtual address, virtual size, raw size, raw pointer) and
// gives no result; tuser = 1 translates the RVA in the beat and gives one
// result beat on the master stream. The status in master tuser tells
// translated, no containing section, or beyond raw data; tdata carries the
// matched section index and the physical address (buffer base + raw
// pointer + offset, modulo 2^64).
// Configuration: write section_count (index 0) and buffer_base (index 1)
// through cfg_we/cfg_index/cfg_data while no beats are in flight.
// Throughput: one beat per cycle while not stalled; the chain of MAX_SECTIONS cells, one
// per table entry, moves every beat down one cell per cycle in order, so a
// load always lands before any later translate reaches its cell.
// Stall: when the result register is full and the receiver holds tready
// low, the whole chain freezes and s_tready drops in the same cycle.
// Reset: clears all beat valid bits, section_count and buffer_base; table
// contents are undefined until loaded.
module section_rva_translator #(
	parameter int unsigned MAX_SECTIONS = srt_pkg::MAX_SECTIONS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// slave stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [3:0] entry_index, [35:4] sect_vaddr, [67:36] sect_vsize,
	// [99:68] sect_rawsize, [131:100] sect_rawptr, [163:132] rva, rest zero
	input  logic [srt_pkg::S_TDATA_W-1:0]  s_tdata,
	// [0] command
	input  logic                           s_tuser,
	// master stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [3:0] section_index, [67:4] physical_address, rest zero
	output logic [srt_pkg::M_TDATA_W-1:0]  m_tdata,
	// [1:0] status
	output logic [1:0]                     m_tuser,
	// configuration write port
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [srt_pkg::ADDR_W-1:0]     cfg_data
);
	import srt_pkg::*;

	`include "assert_macros.svh"

	logic [COUNT_W-1:0] section_count_q;
	logic [ADDR_W-1:0]  buffer_base_q;
	logic               advance;
	beat_t              chain [0:MAX_SECTIONS];
	result_t            result;

	// Register writes; unknown indexes fall to the default arm.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			section_count_q <= '0;
			buffer_base_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COUNT: section_count_q <= cfg_data[COUNT_W-1:0];
				REG_BASE:  buffer_base_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	assign s_tready = advance;

	// Unpack the incoming beat into the head of the chain.
	always_comb begin
		chain[0].valid       = s_tvalid;
		chain[0].cmd         = s_tuser;
		chain[0].entry_index = s_tdata[3:0];
		chain[0].vaddr       = s_tdata[35:4];
		chain[0].vsize       = s_tdata[67:36];
		chain[0].rawsize     = s_tdata[99:68];
		chain[0].rawptr      = s_tdata[131:100];
		chain[0].rva         = s_tdata[163:132];
		chain[0].found       = 1'b0;
		chain[0].hit_idx     = '0;
	end

	// One cell per table entry; the first match wins since later cells
	// skip beats already marked found.
	for (genvar g = 0; g < MAX_SECTIONS; g++) begin : g_cell
		srt_cell #(
			.CELL_ID(g)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.advance      (advance),
			.section_count(section_count_q),
			.beat_in      (chain[g]),
			.beat_out     (chain[g+1])
		);
	end

	srt_resolve u_resolve (
		.clk        (clk),
		.arst_n     (arst_n),
		.buffer_base(buffer_base_q),
		.beat_in    (chain[MAX_SECTIONS]),
		.out_ready  (m_tready),
		.advance    (advance),
		.result     (result)
	);

	assign m_tvalid = result.valid;
	assign m_tuser  = result.status;
	assign m_tdata  = {{(M_TDATA_W - ADDR_W - IDX_W){1'b0}}, result.phys,
		result.section_index};

	`SRT_ASSERT(a_none_is_zero, clk, arst_n, (m_tvalid && m_tuser == ST_NONE) |-> (m_tdata == '0))
	`SRT_ASSERT(a_beyond_no_addr, clk, arst_n, (m_tvalid && m_tuser == ST_BEYOND) |-> (m_tdata[67:4] == '0))
	`SRT_NEVER(a_no_take_when_blocked, clk, arst_n, m_tvalid && !m_tready && s_tready)

endmodule
